// File: rtl/core/glpg_pkg.sv
package glpg_pkg;

    localparam int PIX_W    = 12;
    localparam int DIM_W    = 13;
    localparam int COEF_W   = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;
    localparam int LIGHT_W  = 8;

    localparam int MAX_DIM       = 4096;
    localparam int EXP_STEPS     = 256;
    localparam int ZERO_UNITS    = 6;
    localparam int FRAC_BITS     = 30;
    localparam int STEP_SHIFT    = FRAC_BITS - $clog2(EXP_STEPS);

    localparam int DIFF_W   = DIM_W;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int PROD_W   = SQ_W + COEF_W;
    localparam int TERM_W   = FRAC_BITS + 3;
    localparam int SUM_W    = TERM_W + 1;

    localparam int ROM_DEPTH = ZERO_UNITS * EXP_STEPS;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    localparam logic [DIM_W-1:0]  DIM_LIMIT  = DIM_W'(MAX_DIM);
    localparam logic [TERM_W-1:0] ZERO_TOTAL = TERM_W'(ZERO_UNITS) << FRAC_BITS;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(64);
    localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(64);
    localparam logic [COEF_W-1:0] RST_COEF   = COEF_W'(524288);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COEF_X = 2'd2,
        REG_COEF_Y = 2'd3
    } t_reg_idx;

    // Fixed point with 60 fraction bits for building the exponential table.
    localparam int QBITS        = 60;
    localparam int TAYLOR_TERMS = 28;
    localparam logic [63:0] QONE = 64'd1 << QBITS;

    typedef logic [LIGHT_W-1:0] t_light_rom [ROM_DEPTH];

    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[QBITS+63:QBITS];
    endfunction

    // The value of exp(-u) for u from 0 to 1, summed from its series.
    function automatic logic [63:0] exp_neg_q(input logic [63:0] u);
        logic [63:0] term;
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        term    = QONE;
        pos_sum = QONE;
        neg_sum = '0;
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            term = q_mul(term, u) / 64'(n);
            if (n[0]) begin
                neg_sum += term;
            end else begin
                pos_sum += term;
            end
        end
        return pos_sum - neg_sum;
    endfunction

    // Entry k holds floor(255 * exp(-k/256)); the whole part of k/256 is applied
    // as repeated multiplication by exp(-1).
    function automatic t_light_rom light_rom_init();
        t_light_rom  rom;
        logic [63:0] e_one;
        logic [63:0] v;
        e_one = exp_neg_q(QONE);
        for (int r = 0; r < EXP_STEPS; r++) begin
            v = exp_neg_q(64'(r) << (QBITS - $clog2(EXP_STEPS)));
            for (int u = 0; u < ZERO_UNITS; u++) begin
                rom[u * EXP_STEPS + r] = LIGHT_W'(((v >> 8) * 64'd255) >> (QBITS - 8));
                v = q_mul(v, e_one);
            end
        end
        return rom;
    endfunction

endpackage

// File: rtl/core/gaussian_light_pixel_gen.sv
// Gaussian light spot pixel generator.
// Input channel: i_in_valid with i_pixel_x and i_pixel_y; the block stalls it with
// o_in_stall. Output channel: o_out_valid with o_intensity; the receiver stalls it
// with i_out_stall. A word is taken at a clock edge where valid is high and stall
// is low.
// The spot parameters sit on an APB-style port: image width at 0x0, image height
// at 0x4, the x coefficient at 0x8 and the y coefficient at 0xC. Writes complete
// without wait states and are meant for times when the pipeline is empty.
// The datapath is a five-stage pipeline: centered offsets, squares, products with
// the coefficients, saturation and sum to a table index, and a registered lookup
// in a 1536-entry exponential table. One word per cycle is sustained while the
// receiver does not stall the output.
// Each stage moves when it is empty or the stage after it moves, so bubbles are
// squeezed out and new words are taken while a finished word waits at the output.
// A stall holds each occupied stage with no empty stage after it in place, without loss or repetition.
// Reset empties the pipeline and restores a 64 by 64 image with sigma 16.
module gaussian_light_pixel_gen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [glpg_pkg::PIX_W-1:0]    i_pixel_x,
    input  logic [glpg_pkg::PIX_W-1:0]    i_pixel_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [glpg_pkg::LIGHT_W-1:0]  o_intensity,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [glpg_pkg::ADDR_W-1:0]   paddr,
    input  logic [glpg_pkg::DATA_W-1:0]   pwdata,
    output logic [glpg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import glpg_pkg::*;

    localparam t_light_rom LIGHT_ROM = light_rom_init();

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [COEF_W-1:0] r_coef_x;
    logic [COEF_W-1:0] r_coef_y;

    logic [4:0] r_v;
    logic [4:0] en;
    logic       in_accept;
    logic       cfg_write;
    t_reg_idx   reg_idx;

    logic [DIM_W-1:0]   w_dim;
    logic [DIM_W-1:0]   h_dim;
    logic [DIFF_W-1:0]  dbl_x;
    logic [DIFF_W-1:0]  dbl_y;
    logic [DIFF_W-1:0]  n_dx;
    logic [DIFF_W-1:0]  n_dy;
    logic [DIFF_W-1:0]  r_dx;
    logic [DIFF_W-1:0]  r_dy;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic [PROD_W-1:0]  r_prx;
    logic [PROD_W-1:0]  r_pry;
    logic [TERM_W-1:0]  sat_x;
    logic [TERM_W-1:0]  sat_y;
    logic [SUM_W-1:0]   n_sum;
    logic [ROM_AW-1:0]  r_k;
    logic               r_zero;
    logic [LIGHT_W-1:0] r_intensity;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_coef_x <= RST_COEF;
            r_coef_y <= RST_COEF;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_COEF_X: r_coef_x <= pwdata;
                REG_COEF_Y: r_coef_y <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_COEF_X: prdata = r_coef_x;
            REG_COEF_Y: prdata = r_coef_y;
            default:    prdata = '0;
        endcase
    end

    assign en[4] = !r_v[4] || !i_out_stall;
    assign en[3] = !r_v[3] || en[4];
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];

    assign o_in_stall  = !en[0];
    assign in_accept   = i_in_valid && en[0];
    assign o_out_valid = r_v[4];
    assign o_intensity = r_intensity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int i = 1; i < 5; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_comb begin
        w_dim = (r_width  > DIM_LIMIT) ? DIM_LIMIT : r_width;
        h_dim = (r_height > DIM_LIMIT) ? DIM_LIMIT : r_height;
        dbl_x = {i_pixel_x, 1'b0};
        dbl_y = {i_pixel_y, 1'b0};
        n_dx  = (dbl_x >= w_dim) ? dbl_x - w_dim : w_dim - dbl_x;
        n_dy  = (dbl_y >= h_dim) ? dbl_y - h_dim : h_dim - dbl_y;
    end

    always_comb begin
        sat_x = (r_prx > PROD_W'(ZERO_TOTAL)) ? ZERO_TOTAL : r_prx[TERM_W-1:0];
        sat_y = (r_pry > PROD_W'(ZERO_TOTAL)) ? ZERO_TOTAL : r_pry[TERM_W-1:0];
        n_sum = SUM_W'(sat_x) + SUM_W'(sat_y);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (en[1]) begin
            r_sqx <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sqy <= SQ_W'(r_dy) * SQ_W'(r_dy);
        end
        if (en[2]) begin
            r_prx <= PROD_W'(r_sqx) * PROD_W'(r_coef_x);
            r_pry <= PROD_W'(r_sqy) * PROD_W'(r_coef_y);
        end
        if (en[3]) begin
            r_zero <= n_sum >= SUM_W'(ZERO_TOTAL);
            r_k    <= n_sum[STEP_SHIFT +: ROM_AW];
        end
        if (en[4]) begin
            r_intensity <= r_zero ? '0 : LIGHT_ROM[r_k];
        end
    end

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_v[0])
        else $error("accepted word did not enter the first stage");

    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && !en[2] |=> r_v[2] && $stable(r_prx) && $stable(r_pry))
        else $error("blocked product stage lost or changed its word");

    a_zero_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && en[3] && r_zero |=> o_intensity == '0)
        else $error("exponent beyond the cutoff did not give a dark pixel");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && !r_zero |-> r_k < ROM_AW'(ROM_DEPTH))
        else $error("table index out of range");

endmodule
